FILE: rtl/fpa_pkg.sv
`default_nettype none
package fpa_pkg;

  localparam int unsigned FracBitsDef = 8;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
    OP_LT = 4'd4, OP_LE = 4'd5, OP_GT = 4'd6, OP_GE = 4'd7,
    OP_EQ = 4'd8, OP_NE = 4'd9, OP_INC = 4'd10, OP_DEC = 4'd11,
    OP_MIN = 4'd12, OP_MAX = 4'd13, OP_TOINT = 4'd14, OP_FROMINT = 4'd15
  } action_e;

  typedef struct packed {
    logic [3:0]         action;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } req_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               truth;
    logic               divide_by_zero;
    logic               saturated;
  } rsp_t;

endpackage
`default_nettype wire

FILE: rtl/fpa_div.sv
`default_nettype none
// Pipelined restoring divider: numerator magnitude (up to 32+FracBits bits)
// by a 32-bit divisor magnitude, StepsPerStage quotient bits per stage.
module fpa_div #(
  parameter int unsigned NumW          = 40,
  parameter int unsigned StepsPerStage = 4,
  parameter int unsigned TagW          = 8
) (
  input  wire logic            clk_i,
  input  wire logic            en_i,
  input  wire logic [NumW-1:0] num_i,
  input  wire logic [31:0]     den_i,
  input  wire logic [TagW-1:0] tag_i,
  output logic      [NumW-1:0] quo_o,
  output logic      [32:0]     rem_o,
  output logic      [31:0]     den_o,
  output logic      [TagW-1:0] tag_o
);
  localparam int unsigned Stages = (NumW + StepsPerStage - 1) / StepsPerStage;
  localparam int unsigned PadW   = Stages * StepsPerStage;

  logic [PadW-1:0] q_q   [Stages];
  logic [32:0]     r_q   [Stages];
  logic [31:0]     d_q   [Stages];
  logic [TagW-1:0] t_q   [Stages];

  for (genvar s = 0; s < Stages; s++) begin : g_stage
    logic [PadW-1:0] q_in, q_d;
    logic [32:0]     r_in, r_d;
    logic [31:0]     d_in;
    logic [TagW-1:0] t_in;
    if (s == 0) begin : g_first
      assign q_in = PadW'(num_i);
      assign r_in = '0;
      assign d_in = den_i;
      assign t_in = tag_i;
    end else begin : g_next
      assign q_in = q_q[s-1];
      assign r_in = r_q[s-1];
      assign d_in = d_q[s-1];
      assign t_in = t_q[s-1];
    end
    always_comb begin
      q_d = q_in;
      r_d = r_in;
      for (int k = 0; k < StepsPerStage; k++) begin
        r_d = {r_d[31:0], q_d[PadW-1]};
        q_d = {q_d[PadW-2:0], 1'b0};
        if (r_d >= {1'b0, d_in}) begin
          r_d = r_d - {1'b0, d_in};
          q_d[0] = 1'b1;
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        q_q[s] <= q_d;
        r_q[s] <= r_d;
        d_q[s] <= d_in;
        t_q[s] <= t_in;
      end
    end
  end

  assign quo_o = q_q[Stages-1][NumW-1:0];
  assign rem_o = r_q[Stages-1];
  assign den_o = d_q[Stages-1];
  assign tag_o = t_q[Stages-1];
endmodule
`default_nettype wire

FILE: rtl/fixed_point_q24_8_alu_unit.sv
`default_nettype none
// Every operation alike runs the same path from input to output word: operand register,
// early-result register, the divider's stages and the output register; the divider sets its depth.
// Throughput: one word per cycle; the whole pipeline advances whenever the
// output register is empty or being taken, so a stall freezes every stage.
// Reset clears only the valid bits; payload registers are not reset.
module fixed_point_q24_8_alu_unit #(
  parameter int unsigned FRAC_BITS = fpa_pkg::FracBitsDef
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire fpa_pkg::req_t in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output fpa_pkg::rsp_t      out_data_o
);
  import fpa_pkg::*;

  localparam int unsigned NumW   = 32 + FRAC_BITS;
  localparam int unsigned Steps  = 4;
  localparam int unsigned DivLat = (NumW + Steps - 1) / Steps;
  localparam int unsigned Lat    = DivLat + 3;

  localparam logic signed [65:0] Max32 = 66'sd2147483647;
  localparam logic signed [65:0] Min32 = -66'sd2147483648;

  // How the final stage treats the early result.
  localparam logic [1:0] KindPlain = 2'd0;
  localparam logic [1:0] KindClamp = 2'd1;
  localparam logic [1:0] KindMul   = 2'd2;
  localparam logic [1:0] KindDiv   = 2'd3;

  // The pipeline moves as one: every stage advances when the output
  // register can accept a word.
  logic adv;
  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  // The valid bits travel alongside the data in a shift line.
  logic [Lat-1:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Lat-2:0], in_valid_i};
    end
  end
  assign out_valid_o = vld_q[Lat-1];

  // Stage 1: register the operands.
  req_t s1_q;
  always_ff @(posedge clk_i) begin
    if (adv) s1_q <= in_data_i;
  end

  // Stage 2: the multiplier, the adder and the simple operations, all of
  // which finish here and then ride a delay line past the divider.
  logic signed [65:0] a_x, b_x, wide_d, wide_q;
  logic               truth_d, truth_q, dbz_d, dbz_q, nosat_d, nosat_q;
  logic [1:0]         kind_d, kind_q;
  logic               dneg_d, dneg_q;
  logic [NumW-1:0]    num_d;
  logic [31:0]        den_d;

  always_comb begin
    a_x     = 66'(s1_q.operand_a);
    b_x     = 66'(s1_q.operand_b);
    wide_d  = '0;
    truth_d = 1'b0;
    dbz_d   = 1'b0;
    nosat_d = 1'b0;
    kind_d  = KindClamp;
    dneg_d  = s1_q.operand_a[31] ^ s1_q.operand_b[31];
    num_d   = NumW'(s1_q.operand_a[31] ? -a_x : a_x) << FRAC_BITS;
    den_d   = s1_q.operand_b[31] ? 32'(-b_x) : s1_q.operand_b;
    case (action_e'(s1_q.action))
      OP_ADD:  wide_d = a_x + b_x;
      OP_SUB:  wide_d = a_x - b_x;
      OP_MUL: begin
        wide_d = a_x * b_x;
        kind_d = KindMul;
      end
      OP_DIV: begin
        kind_d = KindDiv;
        dbz_d  = (s1_q.operand_b == '0);
      end
      OP_LT:   begin truth_d = a_x <  b_x; kind_d = KindPlain; end
      OP_LE:   begin truth_d = a_x <= b_x; kind_d = KindPlain; end
      OP_GT:   begin truth_d = a_x >  b_x; kind_d = KindPlain; end
      OP_GE:   begin truth_d = a_x >= b_x; kind_d = KindPlain; end
      OP_EQ:   begin truth_d = a_x == b_x; kind_d = KindPlain; end
      OP_NE:   begin truth_d = a_x != b_x; kind_d = KindPlain; end
      OP_INC:  wide_d = a_x + 66'sd1;
      OP_DEC:  wide_d = a_x - 66'sd1;
      OP_MIN:  begin wide_d = (a_x < b_x) ? a_x : b_x; kind_d = KindPlain; end
      OP_MAX:  begin wide_d = (a_x > b_x) ? a_x : b_x; kind_d = KindPlain; end
      OP_TOINT: begin
        wide_d = a_x >>> FRAC_BITS;
        kind_d = KindPlain;
      end
      default: wide_d = a_x <<< FRAC_BITS;
    endcase
    if (kind_d == KindPlain) nosat_d = 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      wide_q  <= wide_d;
      truth_q <= truth_d;
      dbz_q   <= dbz_d;
      nosat_q <= nosat_d;
      kind_q  <= kind_d;
      dneg_q  <= dneg_d;
    end
  end

  // The divider runs on the same enable; its tag carries the sign.
  logic [NumW-1:0] quo;
  logic [32:0]     rem;
  logic [31:0]     dden;
  logic [0:0]      dtag;
  logic [NumW-1:0] num_q;
  logic [31:0]     den_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      num_q <= num_d;
      den_q <= den_d;
    end
  end

  fpa_div #(.NumW(NumW), .StepsPerStage(Steps), .TagW(1)) u_div (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (num_q),
    .den_i (den_q),
    .tag_i (dneg_q),
    .quo_o (quo),
    .rem_o (rem),
    .den_o (dden),
    .tag_o (dtag)
  );

  // Delay line for the non-divide results, matching the divider latency.
  logic signed [65:0] dw_q    [DivLat];
  logic [4:0]         dflag_q [DivLat];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      dw_q[0]    <= wide_q;
      dflag_q[0] <= {truth_q, dbz_q, nosat_q, kind_q};
      for (int i = 1; i < DivLat; i++) begin
        dw_q[i]    <= dw_q[i-1];
        dflag_q[i] <= dflag_q[i-1];
      end
    end
  end

  // Final stage: rounding, sign and saturation.
  logic signed [65:0] mag, sv;
  logic [NumW:0]      qr;
  logic [4:0]         fl;
  rsp_t               res_d;
  always_comb begin
    fl    = dflag_q[DivLat-1];
    mag   = '0;
    qr    = {1'b0, quo};
    res_d = '0;
    sv    = dw_q[DivLat-1];
    case (fl[1:0])
      KindMul: begin
        mag = (sv < 0) ? -sv : sv;
        mag = (mag + 66'sd1 * (66'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        sv  = (dw_q[DivLat-1] < 0) ? -mag : mag;
      end
      KindDiv: begin
        // Round half away: bump when twice the remainder reaches the divisor.
        if ({rem, 1'b0} >= {2'b0, dden}) qr = qr + 1'b1;
        sv = dtag[0] ? -66'(qr) : 66'(qr);
      end
      default: ;
    endcase
    res_d.truth          = fl[4];
    res_d.divide_by_zero = fl[3];
    if (fl[3]) begin
      res_d.value = '0;
    end else if (sv > Max32) begin
      res_d.value     = 32'sh7fffffff;
      res_d.saturated = 1'b1;
    end else if (sv < Min32) begin
      res_d.value     = 32'sh80000000;
      res_d.saturated = 1'b1;
    end else begin
      res_d.value = sv[31:0];
    end
    if (fl[2]) res_d.saturated = 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (adv) out_data_o <= res_d;
  end
endmodule
`default_nettype wire
